@@ rtl/bslm_pkg.sv @@
// Shared types and codes for the buffer slot lease manager.
// Holds request and status codes, slot table entry and port word layouts.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bslm_pkg;

  localparam logic [3:0] REQ_SUBMIT   = 4'd0;
  localparam logic [3:0] REQ_DISPATCH = 4'd1;
  localparam logic [3:0] REQ_COMPLETE = 4'd2;
  localparam logic [3:0] REQ_CANCEL   = 4'd3;
  localparam logic [3:0] REQ_POLL     = 4'd4;
  localparam logic [3:0] REQ_LEASE    = 4'd5;
  localparam logic [3:0] REQ_RELEASE  = 4'd6;
  localparam logic [3:0] REQ_DISCARD  = 4'd7;
  localparam logic [3:0] REQ_LENGTH   = 4'd8;

  localparam logic [1:0] CFG_FILES    = 2'd0;
  localparam logic [1:0] CFG_SLOTS    = 2'd1;
  localparam logic [1:0] CFG_CAPACITY = 2'd2;

  localparam logic [1:0] IO_OK    = 2'd0;
  localparam logic [1:0] IO_SHORT = 2'd2;

  typedef enum logic [3:0] {
    STAT_OK       = 4'd0,
    STAT_INVALID  = 4'd1,
    STAT_OVERFLOW = 4'd2,
    STAT_BUSY     = 4'd3,
    STAT_AGAIN    = 4'd4,
    STAT_STALE    = 4'd5,
    STAT_CANCELED = 4'd6,
    STAT_READ_ERR = 4'd7,
    STAT_NO_DATA  = 4'd8
  } status_e;

  typedef enum logic [1:0] {
    SS_IDLE    = 2'd0,
    SS_LOADING = 2'd1,
    SS_READY   = 2'd2,
    SS_LEASED  = 2'd3
  } slot_state_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_READ     = 2'd1,
    ERR_NODATA   = 2'd2,
    ERR_CANCELED = 2'd3
  } slot_err_e;

  typedef struct packed {
    slot_state_e state;
    logic [63:0] generation;
    slot_err_e   error;
    logic        cancel;
    logic        dev_lease;
    logic [40:0] length;
    logic [40:0] extent;
  } slot_entry_t;

  localparam slot_entry_t SLOT_RESET = '{
    state: SS_IDLE, generation: 64'd0, error: ERR_NONE, cancel: 1'b0,
    dev_lease: 1'b0, length: 41'd0, extent: 41'd0
  };

  typedef struct packed {
    logic [5:0]  file;
    logic [62:0] offset;
    logic [40:0] dest;
    logic [40:0] length;
  } seg_t;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [3:0]  slot_id;
    logic [63:0] generation;
    logic [5:0]  seg_file;
    logic [62:0] seg_offset;
    logic [40:0] seg_dest;
    logic [62:0] seg_length;
    logic        seg_last;
    logic        side_flag;
    logic [1:0]  io_result;
  } req_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [40:0] length_out;
    logic [3:0]  job_slot;
    logic [63:0] job_generation;
    logic [5:0]  job_file;
    logic [62:0] job_offset;
    logic [40:0] job_dest;
    logic [40:0] job_length;
    logic        last;
  } rsp_t;

  function automatic status_e err_status(slot_err_e err);
    status_e s;
    case (err)
      ERR_READ:     s = STAT_READ_ERR;
      ERR_NODATA:   s = STAT_NO_DATA;
      ERR_CANCELED: s = STAT_CANCELED;
      default:      s = STAT_OK;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

@@ rtl/buffer_slot_lease_manager.sv @@
// Buffer slot lease manager top level: request sequencer, staging, job ring.
// Uses bslm_pkg and bslm_slot_table.
//
// Usage: requests enter on in_i with in_valid_i/in_ready_o, one word each;
// submits arrive one segment per word. Results leave on out_o with
// out_valid_o/out_ready_i. Configuration is written through cfg_we_i,
// cfg_index_i and cfg_data_i while the block is idle.
// One request is handled at a time; in_ready_o is high only while idle.
// Simple requests pass through S_READ and S_RESP, which writes the result
// into the output register, then return to S_IDLE. A submit segment that
// passes its checks goes on to S_OVL, which compares it against each staged
// segment ahead of it (one overlap compare per cycle), then to S_SEG_END; one
// that fails or is skipped goes from S_READ straight to S_SEG_END. A
// committing last segment then copies its segments into the segment store in
// S_COPY before S_RESP. Dispatch alternates S_DWAIT and S_DISP, emitting one
// segment word from S_DISP after each registered segment store read.
// Reset sets all slots idle with generation zero, empties the job ring and
// staging, and loads files_in_use 1, slots_in_use 16, slot_capacity 1 MiB.
// A stalled receiver holds the output register; the next request may be
// taken meanwhile and waits for the register before writing its result.
`timescale 1ns / 1ps
`default_nettype none

module buffer_slot_lease_manager
  import bslm_pkg::*;
#(
  parameter int SLOTS        = 16,
  parameter int MAX_SEGMENTS = 8,
  parameter int RING_DEPTH   = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  req_t             in_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output rsp_t             out_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [40:0] cfg_data_i
);

  localparam int SAW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int EW   = ($clog2(SLOTS + 1) > 5) ? $clog2(SLOTS + 1) : 5;
  localparam int RAW  = $clog2(RING_DEPTH);
  localparam int RCW  = $clog2(RING_DEPTH + 1);
  localparam int QW   = (EW + 1 > RCW) ? EW + 1 : RCW;
  localparam int CW   = $clog2(MAX_SEGMENTS + 1);
  localparam int IW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int SGD  = RING_DEPTH * MAX_SEGMENTS;
  localparam int SGW  = (SGD > 1) ? $clog2(SGD) : 1;

  typedef struct packed {
    logic [3:0]    slot;
    logic [CW-1:0] count;
    logic [63:0]   gen;
  } job_t;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_OVL, S_SEG_END, S_COPY, S_DWAIT, S_DISP, S_RESP
  } state_e;

  state_e state_q, state_d;
  req_t   req_q, req_d;

  logic [6:0]  files_q, files_d;
  logic [4:0]  slots_q, slots_d;
  logic [40:0] cap_q, cap_d;

  logic [RAW-1:0] head_q, head_d, tail_q, tail_d;
  logic [RCW-1:0] count_q, count_d;

  logic [CW-1:0] stage_count_q, stage_seen_q, i_q, disp_n_q;
  logic [CW-1:0] stage_count_d, stage_seen_d, i_d, disp_n_d;
  status_e       stage_error_q, stage_error_d;
  logic          stage_over_q, stage_over_d;
  logic [40:0]   stage_extent_q, cur_end_q, stage_extent_d, cur_end_d;
  seg_t          stg_q [MAX_SEGMENTS];
  seg_t          stg_d [MAX_SEGMENTS];
  logic [40:0]   stg_end_q [MAX_SEGMENTS];
  logic [40:0]   stg_end_d [MAX_SEGMENTS];

  job_t  disp_meta_q, disp_meta_d;
  status_e resp_status_q, resp_status_d;
  logic [40:0] resp_len_q, resp_len_d;
  rsp_t  out_q, out_d;
  logic  out_valid_q, out_valid_d;

  logic          slot_we_q, slot_we_d;
  logic [SAW-1:0] slot_waddr_q, slot_waddr_d;
  slot_entry_t   slot_wdata_q, slot_wdata_d;
  slot_entry_t   slot_rd;

  job_t          job_mem [RING_DEPTH];
  job_t          job_rd_q;
  logic          job_we_q, job_we_d;
  logic [RAW-1:0] job_waddr_q, job_waddr_d;
  job_t          job_wdata_q, job_wdata_d;

  seg_t          seg_mem [SGD];
  seg_t          seg_rd_q;
  logic          seg_we_q, seg_we_d;
  logic [SGW-1:0] seg_waddr_q, seg_raddr_q, seg_waddr_d, seg_raddr_d;
  seg_t          seg_wdata_q, seg_wdata_d;

  logic in_acc, out_free;
  logic [EW-1:0] eff;
  logic [QW-1:0] ring_q;
  logic sok;
  logic [63:0] sum_ovf, sum_cap;
  logic [IW-1:0] idx;
  logic ring_full;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign eff = (EW'(slots_q) < EW'(SLOTS)) ? EW'(slots_q) : EW'(SLOTS);
  assign ring_q = (QW'(eff) * QW'(2) > QW'(RING_DEPTH)) ? QW'(RING_DEPTH)
                                                         : QW'(eff) * QW'(2);
  assign sok = EW'(req_q.slot_id) < eff;
  assign sum_ovf = {1'b0, req_q.seg_offset} + {1'b0, req_q.seg_length};
  assign sum_cap = {23'd0, req_q.seg_dest} + {1'b0, req_q.seg_length};
  assign idx = i_q[IW-1:0];
  assign ring_full = QW'(count_q) >= ring_q;

  function automatic logic [RAW-1:0] ring_next(logic [RAW-1:0] p, logic [QW-1:0] q);
    logic [QW-1:0] s;
    s = QW'(p) + QW'(1);
    return (s >= q) ? RAW'(0) : RAW'(s);
  endfunction

  bslm_slot_table #(
    .SLOTS (SLOTS),
    .SAW   (SAW)
  ) u_slot_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (SAW'(in_i.slot_id)),
    .rd_data_o (slot_rd),
    .wr_en_i   (slot_we_q),
    .wr_addr_i (slot_waddr_q),
    .wr_data_i (slot_wdata_q)
  );

  always_ff @(posedge clk_i) begin
    if (job_we_q) begin
      job_mem[job_waddr_q] <= job_wdata_q;
    end
    if (in_acc) begin
      job_rd_q <= job_mem[head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (seg_we_q) begin
      seg_mem[seg_waddr_q] <= seg_wdata_q;
    end
    seg_rd_q <= seg_mem[seg_raddr_q];
  end

  always_comb begin
    state_d        = state_q;
    req_d          = req_q;
    files_d        = files_q;
    slots_d        = slots_q;
    cap_d          = cap_q;
    head_d         = head_q;
    tail_d         = tail_q;
    count_d        = count_q;
    stage_count_d  = stage_count_q;
    stage_seen_d   = stage_seen_q;
    stage_error_d  = stage_error_q;
    stage_over_d   = stage_over_q;
    stage_extent_d = stage_extent_q;
    cur_end_d      = cur_end_q;
    i_d            = i_q;
    disp_n_d       = disp_n_q;
    disp_meta_d    = disp_meta_q;
    resp_status_d  = resp_status_q;
    resp_len_d     = resp_len_q;
    out_d          = out_q;
    out_valid_d    = out_valid_q;
    slot_we_d      = 1'b0;
    slot_waddr_d   = slot_waddr_q;
    slot_wdata_d   = slot_wdata_q;
    job_we_d       = 1'b0;
    job_waddr_d    = job_waddr_q;
    job_wdata_d    = job_wdata_q;
    seg_we_d       = 1'b0;
    seg_waddr_d    = seg_waddr_q;
    seg_raddr_d    = seg_raddr_q;
    seg_wdata_d    = seg_wdata_q;
    stg_d          = stg_q;
    stg_end_d      = stg_end_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FILES:    files_d = cfg_data_i[6:0];
        CFG_SLOTS:    slots_d = cfg_data_i[4:0];
        CFG_CAPACITY: cap_d   = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          req_d   = in_i;
          state_d = S_READ;
        end
      end

      S_READ: begin
        slot_waddr_d = SAW'(req_q.slot_id);
        resp_len_d   = '0;
        state_d      = S_RESP;
        if (req_q.req_type == REQ_SUBMIT) begin
          state_d = S_SEG_END;
          if (stage_seen_q == CW'(MAX_SEGMENTS)) begin
            stage_over_d = 1'b1;
          end else begin
            stage_seen_d = stage_seen_q + CW'(1);
            if (stage_error_q == STAT_OK) begin
              if ({1'b0, req_q.seg_file} >= files_q || req_q.seg_length == '0) begin
                stage_error_d = STAT_INVALID;
              end else if (sum_ovf[63]) begin
                stage_error_d = STAT_OVERFLOW;
              end else if (sum_cap > {23'd0, cap_q}) begin
                stage_error_d = STAT_BUSY;
              end else begin
                cur_end_d = sum_cap[40:0];
                i_d       = '0;
                state_d   = S_OVL;
              end
            end
          end
        end else if (req_q.req_type == REQ_DISPATCH) begin
          if (count_q == '0) begin
            resp_status_d = STAT_AGAIN;
          end else begin
            disp_meta_d   = job_rd_q;
            disp_n_d      = job_rd_q.count;
            head_d        = ring_next(head_q, ring_q);
            count_d       = count_q - RCW'(1);
            resp_status_d = STAT_OK;
            if (job_rd_q.count != '0) begin
              i_d         = '0;
              seg_raddr_d = SGW'(head_q) * SGW'(MAX_SEGMENTS);
              state_d     = S_DWAIT;
            end
          end
        end else if (req_q.req_type > REQ_LENGTH || !sok) begin
          resp_status_d = STAT_INVALID;
        end else if (req_q.req_type == REQ_COMPLETE) begin
          if (slot_rd.generation != req_q.generation || slot_rd.state != SS_LOADING) begin
            resp_status_d = STAT_STALE;
          end else begin
            slot_wdata_d       = slot_rd;
            slot_wdata_d.state = SS_READY;
            if (slot_rd.cancel) begin
              slot_wdata_d.error  = ERR_CANCELED;
              slot_wdata_d.length = '0;
            end else if (req_q.io_result == IO_OK) begin
              slot_wdata_d.error  = ERR_NONE;
              slot_wdata_d.length = slot_rd.extent;
            end else if (req_q.io_result == IO_SHORT) begin
              slot_wdata_d.error  = ERR_NODATA;
              slot_wdata_d.length = '0;
            end else begin
              slot_wdata_d.error  = ERR_READ;
              slot_wdata_d.length = '0;
            end
            slot_we_d     = 1'b1;
            resp_status_d = STAT_OK;
          end
        end else if (req_q.req_type == REQ_LENGTH) begin
          resp_status_d = STAT_OK;
          if (slot_rd.state == SS_LEASED && slot_rd.generation == req_q.generation) begin
            resp_len_d = slot_rd.length;
          end
        end else if (req_q.req_type == REQ_DISCARD && req_q.generation == '0) begin
          resp_status_d = STAT_INVALID;
        end else if (slot_rd.generation != req_q.generation) begin
          resp_status_d = STAT_STALE;
        end else begin
          slot_wdata_d  = slot_rd;
          resp_status_d = STAT_OK;
          case (req_q.req_type)
            REQ_CANCEL: begin
              if (slot_rd.state == SS_LOADING) begin
                slot_wdata_d.cancel = 1'b1;
                slot_we_d           = 1'b1;
              end else if (slot_rd.state == SS_READY) begin
                slot_wdata_d.error  = ERR_CANCELED;
                slot_wdata_d.length = '0;
                slot_we_d           = 1'b1;
              end else begin
                resp_status_d = STAT_BUSY;
              end
            end
            REQ_POLL: begin
              resp_status_d = (slot_rd.state == SS_LOADING) ? STAT_AGAIN
                                                            : err_status(slot_rd.error);
            end
            REQ_LEASE: begin
              if (slot_rd.state != SS_READY || slot_rd.error != ERR_NONE) begin
                resp_status_d = STAT_BUSY;
              end else begin
                slot_wdata_d.state     = SS_LEASED;
                slot_wdata_d.dev_lease = req_q.side_flag;
                slot_we_d              = 1'b1;
              end
            end
            REQ_RELEASE: begin
              if (slot_rd.state != SS_LEASED) begin
                resp_status_d = STAT_INVALID;
              end else if (slot_rd.dev_lease && !req_q.side_flag) begin
                resp_status_d = STAT_BUSY;
              end else begin
                slot_wdata_d.state     = SS_READY;
                slot_wdata_d.dev_lease = 1'b0;
                slot_we_d              = 1'b1;
              end
            end
            default: begin
              if (slot_rd.state != SS_READY) begin
                resp_status_d = STAT_BUSY;
              end else begin
                slot_wdata_d.state     = SS_IDLE;
                slot_wdata_d.length    = '0;
                slot_wdata_d.error     = ERR_NONE;
                slot_wdata_d.cancel    = 1'b0;
                slot_wdata_d.dev_lease = 1'b0;
                slot_we_d              = 1'b1;
              end
            end
          endcase
        end
      end

      S_OVL: begin
        if (i_q == stage_count_q) begin
          stg_d[stage_count_q[IW-1:0]] = '{
            file: req_q.seg_file, offset: req_q.seg_offset,
            dest: req_q.seg_dest, length: req_q.seg_length[40:0]
          };
          stg_end_d[stage_count_q[IW-1:0]] = cur_end_q;
          stage_count_d = stage_count_q + CW'(1);
          if (cur_end_q > stage_extent_q) begin
            stage_extent_d = cur_end_q;
          end
          state_d = S_SEG_END;
        end else if (req_q.seg_dest < stg_end_q[idx] && stg_q[idx].dest < cur_end_q) begin
          stage_error_d = STAT_INVALID;
          state_d       = S_SEG_END;
        end else begin
          i_d = i_q + CW'(1);
        end
      end

      S_SEG_END: begin
        if (!req_q.seg_last) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_RESP;
          if (!sok || req_q.generation == '0 || stage_over_q ||
              (stage_count_q == '0 && stage_error_q == STAT_OK)) begin
            resp_status_d = STAT_INVALID;
          end else if (stage_error_q != STAT_OK) begin
            resp_status_d = stage_error_q;
          end else if (stage_extent_q > cap_q || slot_rd.state == SS_LOADING ||
                       slot_rd.state == SS_LEASED) begin
            resp_status_d = STAT_BUSY;
          end else if (ring_full) begin
            resp_status_d = STAT_AGAIN;
          end else begin
            slot_wdata_d            = slot_rd;
            slot_wdata_d.generation = req_q.generation;
            slot_wdata_d.length     = '0;
            slot_wdata_d.error      = ERR_NONE;
            slot_wdata_d.cancel     = 1'b0;
            slot_wdata_d.state      = SS_LOADING;
            slot_wdata_d.extent     = stage_extent_q;
            slot_we_d               = 1'b1;
            job_we_d                = 1'b1;
            job_waddr_d             = tail_q;
            job_wdata_d             = '{slot: req_q.slot_id, count: stage_count_q,
                                        gen: req_q.generation};
            tail_d                  = ring_next(tail_q, ring_q);
            count_d                 = count_q + RCW'(1);
            resp_status_d           = STAT_OK;
            i_d                     = '0;
            state_d                 = S_COPY;
          end
          stage_count_d  = '0;
          stage_seen_d   = '0;
          stage_error_d  = STAT_OK;
          stage_over_d   = 1'b0;
          stage_extent_d = '0;
        end
      end

      S_COPY: begin
        if (i_q == job_wdata_q.count) begin
          state_d = S_RESP;
        end else begin
          seg_we_d    = 1'b1;
          seg_waddr_d = SGW'(job_waddr_q) * SGW'(MAX_SEGMENTS) + SGW'(i_q);
          seg_wdata_d = stg_q[idx];
          i_d         = i_q + CW'(1);
        end
      end

      S_DWAIT: begin
        state_d = S_DISP;
      end

      S_DISP: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.status         = STAT_OK;
          out_d.length_out     = '0;
          out_d.job_slot       = disp_meta_q.slot;
          out_d.job_generation = disp_meta_q.gen;
          out_d.job_file       = seg_rd_q.file;
          out_d.job_offset     = seg_rd_q.offset;
          out_d.job_dest       = seg_rd_q.dest;
          out_d.job_length     = seg_rd_q.length;
          out_d.last           = (i_q + CW'(1) == disp_n_q);
          if (i_q + CW'(1) == disp_n_q) begin
            state_d = S_IDLE;
          end else begin
            i_d         = i_q + CW'(1);
            seg_raddr_d = seg_raddr_q + SGW'(1);
            state_d     = S_DWAIT;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d            = '0;
          out_d.status     = resp_status_q;
          out_d.length_out = resp_len_q;
          out_d.last       = 1'b1;
          state_d          = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      req_q          <= '0;
      files_q        <= 7'd1;
      slots_q        <= 5'd16;
      cap_q          <= 41'd1048576;
      head_q         <= '0;
      tail_q         <= '0;
      count_q        <= '0;
      stage_count_q  <= '0;
      stage_seen_q   <= '0;
      stage_error_q  <= STAT_OK;
      stage_over_q   <= 1'b0;
      stage_extent_q <= '0;
      cur_end_q      <= '0;
      i_q            <= '0;
      disp_n_q       <= '0;
      disp_meta_q    <= '0;
      resp_status_q  <= STAT_OK;
      resp_len_q     <= '0;
      out_q          <= '0;
      out_valid_q    <= 1'b0;
      slot_we_q      <= 1'b0;
      slot_waddr_q   <= '0;
      slot_wdata_q   <= SLOT_RESET;
      job_we_q       <= 1'b0;
      job_waddr_q    <= '0;
      job_wdata_q    <= '0;
      seg_we_q       <= 1'b0;
      seg_waddr_q    <= '0;
      seg_raddr_q    <= '0;
      seg_wdata_q    <= '0;
      for (int k = 0; k < MAX_SEGMENTS; k++) begin
        stg_q[k]     <= '0;
        stg_end_q[k] <= '0;
      end
    end else begin
      state_q        <= state_d;
      req_q          <= req_d;
      files_q        <= files_d;
      slots_q        <= slots_d;
      cap_q          <= cap_d;
      head_q         <= head_d;
      tail_q         <= tail_d;
      count_q        <= count_d;
      stage_count_q  <= stage_count_d;
      stage_seen_q   <= stage_seen_d;
      stage_error_q  <= stage_error_d;
      stage_over_q   <= stage_over_d;
      stage_extent_q <= stage_extent_d;
      cur_end_q      <= cur_end_d;
      i_q            <= i_d;
      disp_n_q       <= disp_n_d;
      disp_meta_q    <= disp_meta_d;
      resp_status_q  <= resp_status_d;
      resp_len_q     <= resp_len_d;
      out_q          <= out_d;
      out_valid_q    <= out_valid_d;
      slot_we_q      <= slot_we_d;
      slot_waddr_q   <= slot_waddr_d;
      slot_wdata_q   <= slot_wdata_d;
      job_we_q       <= job_we_d;
      job_waddr_q    <= job_waddr_d;
      job_wdata_q    <= job_wdata_d;
      seg_we_q       <= seg_we_d;
      seg_waddr_q    <= seg_waddr_d;
      seg_raddr_q    <= seg_raddr_d;
      seg_wdata_q    <= seg_wdata_d;
      for (int k = 0; k < MAX_SEGMENTS; k++) begin
        stg_q[k]     <= stg_d[k];
        stg_end_q[k] <= stg_end_d[k];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/bslm_slot_table.sv @@
// Slot table memory with registered read and per-entry valid bits.
// Entries never written read as the reset entry. Uses bslm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bslm_slot_table
  import bslm_pkg::*;
#(
  parameter int SLOTS = 16,
  parameter int SAW   = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             rd_en_i,
  input  wire logic [SAW-1:0]   rd_addr_i,
  output slot_entry_t           rd_data_o,
  input  wire logic             wr_en_i,
  input  wire logic [SAW-1:0]   wr_addr_i,
  input  slot_entry_t           wr_data_i
);

  slot_entry_t mem [SLOTS];
  slot_entry_t rd_q;
  logic [SLOTS-1:0] vld_q;
  logic rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : SLOT_RESET;

endmodule

`default_nettype wire

@@ tb/sv/bslm_checker.sv @@
// Checker for the buffer slot lease manager: tracks slot table, job ring and staging,
// predicts each result word from accepted request words and compares field by field.
// Depends on bslm_pkg.
`timescale 1ns / 1ps

module bslm_checker
  import bslm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  req_t        in_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  rsp_t        out_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [40:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_o
);

  localparam int NSLOT  = 16;
  localparam int NSEG   = 8;
  localparam int NJOB   = 32;
  localparam logic [63:0] OFS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  logic [6:0]  files_cfg;
  logic [4:0]  slots_cfg;
  logic [40:0] cap_cfg;

  slot_state_e slot_st   [NSLOT];
  logic [63:0] slot_gen  [NSLOT];
  slot_err_e   slot_err  [NSLOT];
  bit          slot_cxl  [NSLOT];
  bit          slot_gpu  [NSLOT];
  logic [40:0] slot_len  [NSLOT];
  logic [40:0] slot_ext  [NSLOT];

  logic [3:0]  job_slot_q [NJOB];
  logic [63:0] job_gen_q  [NJOB];
  int          job_nseg_q [NJOB];
  seg_t        seg_mem    [NJOB*NSEG];
  int          head, tail, count;

  int          stg_n, stg_seen;
  logic [3:0]  stg_err;
  bit          stg_over;
  logic [41:0] stg_ext;
  seg_t        stg [NSEG];

  rsp_t        pending_words[$];

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) report(what, got, want);
  endtask

  task automatic push_word(logic [3:0] s, logic [40:0] l, logic [3:0] js, logic [63:0] jg,
                           seg_t sg, bit lst);
    rsp_t w;
    w.status = s; w.length_out = l; w.job_slot = js; w.job_generation = jg;
    w.job_file = sg.file; w.job_offset = sg.offset; w.job_dest = sg.dest;
    w.job_length = sg.length; w.last = lst;
    pending_words.push_back(w);
  endtask

  task automatic push_status(logic [3:0] s);
    push_word(s, '0, '0, '0, '0, 1'b1);
  endtask

  function automatic int ring_size(int eff);
    return (eff * 2 > NJOB) ? NJOB : eff * 2;
  endfunction

  function automatic int ring_next(int idx, int q);
    return (idx + 1 >= q) ? 0 : idx + 1;
  endfunction

  task automatic stage_clear();
    stg_n = 0; stg_seen = 0; stg_err = '0; stg_over = 0; stg_ext = '0;
  endtask

  task automatic model_reset();
    files_cfg = 7'd1; slots_cfg = 5'd16; cap_cfg = 41'd1048576;
    for (int i = 0; i < NSLOT; i++) begin
      slot_st[i] = SS_IDLE; slot_gen[i] = '0; slot_err[i] = ERR_NONE;
      slot_cxl[i] = 0; slot_gpu[i] = 0; slot_len[i] = '0; slot_ext[i] = '0;
    end
    head = 0; tail = 0; count = 0;
    stage_clear();
    pending_words.delete();
  endtask

  task automatic stage_segment(req_t r);
    logic [63:0] room;
    logic [41:0] seg_end, pend;
    if (stg_seen >= NSEG) begin
      stg_over = 1;
      return;
    end
    stg_seen++;
    if (stg_err != 0) return;
    if (r.seg_file >= files_cfg || r.seg_length == 0) begin
      stg_err = STAT_INVALID;
      return;
    end
    room = OFS_MAX - {1'b0, r.seg_offset};
    if ({1'b0, r.seg_length} > room) begin
      stg_err = STAT_OVERFLOW;
      return;
    end
    if (r.seg_dest > cap_cfg || {1'b0, r.seg_length} > {23'd0, cap_cfg - r.seg_dest}) begin
      stg_err = STAT_BUSY;
      return;
    end
    seg_end = {1'b0, r.seg_dest} + {1'b0, r.seg_length[40:0]};
    for (int i = 0; i < stg_n; i++) begin
      pend = {1'b0, stg[i].dest} + {1'b0, stg[i].length};
      if ({1'b0, r.seg_dest} < pend && {1'b0, stg[i].dest} < seg_end) begin
        stg_err = STAT_INVALID;
        return;
      end
    end
    stg[stg_n] = '{file: r.seg_file, offset: r.seg_offset, dest: r.seg_dest,
                   length: r.seg_length[40:0]};
    stg_n++;
    if (seg_end > stg_ext) stg_ext = seg_end;
  endtask

  function automatic logic [3:0] commit(int sid, logic [63:0] g, int eff);
    int q, t;
    q = ring_size(eff);
    if (stg_ext > {1'b0, cap_cfg} || slot_st[sid] == SS_LOADING || slot_st[sid] == SS_LEASED)
      return STAT_BUSY;
    if (count >= q) return STAT_AGAIN;
    slot_gen[sid] = g; slot_len[sid] = '0; slot_err[sid] = ERR_NONE;
    slot_cxl[sid] = 0; slot_st[sid] = SS_LOADING; slot_ext[sid] = stg_ext[40:0];
    t = tail % NJOB;
    job_slot_q[t] = sid[3:0]; job_gen_q[t] = g; job_nseg_q[t] = stg_n;
    for (int i = 0; i < stg_n; i++) seg_mem[t*NSEG + i] = stg[i];
    tail = ring_next(t, q);
    count++;
    return STAT_OK;
  endfunction

  task automatic predict(req_t r);
    int eff, sid, h, n;
    bit sok;
    logic [3:0] s;
    slot_err_e e;
    eff = (slots_cfg < NSLOT) ? slots_cfg : NSLOT;
    sid = r.slot_id;
    sok = sid < eff;
    if (r.req_type == REQ_SUBMIT) begin
      stage_segment(r);
      if (!r.seg_last) return;
      if (!sok || r.generation == 0 || stg_over || (stg_n == 0 && stg_err == 0))
        s = STAT_INVALID;
      else if (stg_err != 0) s = stg_err;
      else s = commit(sid, r.generation, eff);
      stage_clear();
      push_status(s);
    end else if (r.req_type == REQ_DISPATCH) begin
      if (count == 0) begin
        push_status(STAT_AGAIN);
        return;
      end
      h = head % NJOB;
      n = job_nseg_q[h];
      for (int i = 0; i < n; i++)
        push_word(STAT_OK, '0, job_slot_q[h], job_gen_q[h], seg_mem[h*NSEG + i], i + 1 == n);
      head = ring_next(h, ring_size(eff));
      count--;
      if (n == 0) push_status(STAT_OK);
    end else if (r.req_type > REQ_LENGTH || !sok) begin
      push_status(STAT_INVALID);
    end else if (r.req_type == REQ_COMPLETE) begin
      if (slot_gen[sid] != r.generation || slot_st[sid] != SS_LOADING) begin
        push_status(STAT_STALE);
        return;
      end
      e = (r.io_result == IO_OK) ? ERR_NONE : (r.io_result == IO_SHORT) ? ERR_NODATA : ERR_READ;
      if (slot_cxl[sid]) e = ERR_CANCELED;
      slot_err[sid] = e;
      slot_len[sid] = (e != ERR_NONE) ? '0 : slot_ext[sid];
      slot_st[sid] = SS_READY;
      push_status(STAT_OK);
    end else if (r.req_type == REQ_LENGTH) begin
      push_word(STAT_OK, (slot_st[sid] == SS_LEASED && slot_gen[sid] == r.generation) ?
                slot_len[sid] : '0, '0, '0, '0, 1'b1);
    end else if (r.req_type == REQ_DISCARD && r.generation == 0) begin
      push_status(STAT_INVALID);
    end else if (slot_gen[sid] != r.generation) begin
      push_status(STAT_STALE);
    end else if (r.req_type == REQ_CANCEL) begin
      if (slot_st[sid] == SS_LOADING) begin
        slot_cxl[sid] = 1;
        push_status(STAT_OK);
      end else if (slot_st[sid] == SS_READY) begin
        slot_err[sid] = ERR_CANCELED; slot_len[sid] = '0;
        push_status(STAT_OK);
      end else push_status(STAT_BUSY);
    end else if (r.req_type == REQ_POLL) begin
      if (slot_st[sid] == SS_LOADING) push_status(STAT_AGAIN);
      else case (slot_err[sid])
        ERR_READ:     push_status(STAT_READ_ERR);
        ERR_NODATA:   push_status(STAT_NO_DATA);
        ERR_CANCELED: push_status(STAT_CANCELED);
        default:      push_status(STAT_OK);
      endcase
    end else if (r.req_type == REQ_LEASE) begin
      if (slot_st[sid] != SS_READY || slot_err[sid] != ERR_NONE) push_status(STAT_BUSY);
      else begin
        slot_st[sid] = SS_LEASED; slot_gpu[sid] = r.side_flag;
        push_status(STAT_OK);
      end
    end else if (r.req_type == REQ_RELEASE) begin
      if (slot_st[sid] != SS_LEASED) push_status(STAT_INVALID);
      else if (slot_gpu[sid] && !r.side_flag) push_status(STAT_BUSY);
      else begin
        slot_st[sid] = SS_READY; slot_gpu[sid] = 0;
        push_status(STAT_OK);
      end
    end else begin
      if (slot_st[sid] != SS_READY) push_status(STAT_BUSY);
      else begin
        slot_st[sid] = SS_IDLE; slot_len[sid] = '0; slot_err[sid] = ERR_NONE;
        slot_cxl[sid] = 0; slot_gpu[sid] = 0;
        push_status(STAT_OK);
      end
    end
  endtask

  task automatic compare_word(rsp_t got);
    rsp_t want;
    results_o++;
    if (pending_words.size() == 0) begin
      report("unexpected word, status", got.status, '0);
      return;
    end
    want = pending_words.pop_front();
    check_field("status", got.status, want.status);
    check_field("length_out", got.length_out, want.length_out);
    check_field("job_slot", got.job_slot, want.job_slot);
    check_field("job_generation", got.job_generation, want.job_generation);
    check_field("job_file", got.job_file, want.job_file);
    check_field("job_offset", got.job_offset, want.job_offset);
    check_field("job_dest", got.job_dest, want.job_dest);
    check_field("job_length", got.job_length, want.job_length);
    check_field("last", got.last, want.last);
  endtask

  initial begin
    fail_count_o = 0;
    results_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_reset();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_FILES:    files_cfg = cfg_data_i[6:0];
          CFG_SLOTS:    slots_cfg = cfg_data_i[4:0];
          CFG_CAPACITY: cap_cfg = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) compare_word(out_i);
      if (in_valid_i && in_ready_i) predict(in_i);
    end
    pending_o = pending_words.size();
  end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top for the buffer slot lease manager: clock, reset, request stimulus,
// register phases and verdict. Depends on bslm_pkg, bslm_checker and the RTL top.
`timescale 1ns / 1ps

module tb;
  import bslm_pkg::*;

  localparam int LIMIT = 400000;
  localparam int SETTLE = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  req_t        in_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  rsp_t        out_word;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_FILES;
  logic [40:0] cfg_data = '0;

  int          fail_count, pending, results;
  int          sent = 0;
  int          cycles = 0;
  bit          no_gaps = 0;
  bit          hold_req = 0;
  int          files_now = 1, slots_now = 16;
  longint unsigned cap_now = 1048576;
  logic [63:0] gen_of [16];

  buffer_slot_lease_manager i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_i(in_word),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_o(out_word),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  bslm_checker i_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_i(in_word),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_i(out_word),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending), .results_o(results)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send(req_t r);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_word <= r;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    sent++;
  endtask

  task automatic op(logic [3:0] kind, logic [3:0] sid, logic [63:0] g, bit side,
                    logic [1:0] io);
    req_t r;
    r = '0;
    r.req_type = kind; r.slot_id = sid; r.generation = g;
    r.side_flag = side; r.io_result = io;
    r.seg_offset = 63'(rand64()); r.seg_length = 63'(rand64()); r.seg_file = 6'($urandom);
    r.seg_dest = 41'(rand64()); r.seg_last = 1'($urandom);
    send(r);
  endtask

  task automatic seg(logic [3:0] sid, logic [63:0] g, logic [5:0] f, logic [62:0] ofs,
                     logic [40:0] dest, logic [62:0] len, bit lst);
    req_t r;
    r = '0;
    r.req_type = REQ_SUBMIT; r.slot_id = sid; r.generation = g;
    r.seg_file = f; r.seg_offset = ofs; r.seg_dest = dest; r.seg_length = len;
    r.seg_last = lst; r.side_flag = 1'($urandom); r.io_result = 2'($urandom);
    send(r);
  endtask

  task automatic set_regs(int files, int slots, longint unsigned cap);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we <= 1'b1; cfg_index <= CFG_FILES; cfg_data <= 41'(files);
    @(posedge clk_i);
    cfg_index <= CFG_SLOTS; cfg_data <= 41'(slots);
    @(posedge clk_i);
    cfg_index <= CFG_CAPACITY; cfg_data <= cap[40:0];
    @(posedge clk_i);
    cfg_we <= 1'b0;
    files_now = files; slots_now = slots; cap_now = cap & 64'h1FF_FFFF_FFFF;
  endtask

  task automatic submit_job();
    int eff, nseg;
    logic [3:0] sid;
    logic [63:0] g;
    longint unsigned base, piece, dest, len;
    eff = (slots_now > 16) ? 16 : slots_now;
    sid = 4'($urandom_range(0, (eff > 15) ? 15 : eff));
    g = ($urandom_range(0, 1) == 1) ? 64'($urandom_range(1, 3)) : rand64();
    if ($urandom_range(0, 19) == 0) g = '0;
    gen_of[sid] = g;
    case ($urandom_range(0, 9))
      0:       nseg = 9;
      1, 2:    nseg = $urandom_range(4, 8);
      default: nseg = $urandom_range(1, 3);
    endcase
    base = (cap_now == 0) ? 0 : rand64() % (cap_now / 2 + 1);
    piece = cap_now / (2 * nseg);
    dest = base;
    for (int i = 0; i < nseg; i++) begin
      len = (piece == 0) ? 1 : 1 + rand64() % piece;
      if ($urandom_range(0, 9) == 0)
        seg(sid, g, 6'($urandom), 63'(rand64()), 41'(rand64()),
            ($urandom_range(0, 1) == 1) ? '0 : 63'(rand64()), i == nseg - 1);
      else
        seg(sid, g, 6'($urandom_range(0, (files_now > 0) ? files_now - 1 : 0)),
            63'(rand64() >> 2), 41'(dest), 63'(len), i == nseg - 1);
      dest += len;
    end
  endtask

  task automatic random_item();
    int pick, eff;
    logic [3:0] sid;
    logic [63:0] g;
    pick = $urandom_range(0, 99);
    eff = (slots_now > 16) ? 16 : slots_now;
    if (pick < 30) begin
      submit_job();
    end else if (pick < 45) begin
      op(REQ_DISPATCH, 4'($urandom), rand64(), 1'($urandom), 2'($urandom));
    end else begin
      sid = ($urandom_range(0, 9) < 8 && eff > 0) ? 4'($urandom_range(0, eff - 1))
                                                  : 4'($urandom);
      case ($urandom_range(0, 9))
        0:       g = rand64();
        1:       g = '0;
        default: g = gen_of[sid];
      endcase
      op((pick < 47) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(2, 8)), sid, g,
         1'($urandom), 2'($urandom_range(0, 3)));
    end
  endtask

  task automatic random_phase(int files, int slots, longint unsigned cap, int n, bit hold);
    set_regs(files, slots, cap);
    no_gaps = ($urandom_range(0, 2) == 0);
    for (int i = 0; i < n; i++) begin
      if (hold && i == 10) hold_req = 1;
      random_item();
    end
  endtask

  initial begin
    int gap;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_req = 0;
      end else begin
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  initial begin
    for (int i = 0; i < 16; i++) gen_of[i] = 64'd1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    seg(0, 5, 0, 0, 0, 100, 1);
    op(REQ_DISPATCH, 0, 0, 0, IO_OK);
    op(REQ_COMPLETE, 0, 5, 0, IO_OK);
    op(REQ_POLL, 0, 5, 0, IO_OK);
    op(REQ_LEASE, 0, 5, 1, IO_OK);
    op(REQ_LENGTH, 0, 5, 0, IO_OK);
    op(REQ_RELEASE, 0, 5, 0, IO_OK);
    op(REQ_RELEASE, 0, 5, 1, IO_OK);
    op(REQ_DISCARD, 0, 5, 0, IO_OK);
    op(REQ_DISCARD, 0, 0, 0, IO_OK);
    seg(1, 7, 0, 0, 0, 64, 0);
    seg(1, 7, 0, 0, 32, 64, 1);
    seg(1, 7, 1, 0, 0, 8, 1);
    seg(1, 7, 0, 0, 0, 0, 1);
    seg(1, 7, 0, 63'h7FFF_FFFF_FFFF_FFFF, 0, 2, 1);
    seg(1, 7, 0, 0, 41'd1048576, 1, 1);
    seg(1, 0, 0, 0, 0, 8, 1);
    op(4'd15, 3, 7, 0, IO_OK);
    op(REQ_DISPATCH, 0, 0, 0, IO_OK);
    seg(2, 9, 0, 0, 0, 8, 1);
    op(REQ_CANCEL, 2, 9, 0, IO_OK);
    op(REQ_COMPLETE, 2, 9, 0, 2'd3);
    op(REQ_POLL, 2, 9, 0, IO_OK);
    op(REQ_COMPLETE, 2, 8, 0, IO_OK);

    random_phase(64, 16, 64'd1048576, 40, 0);
    random_phase(1, 1, 1, 24, 0);
    random_phase(7, 4, 4096, 52, 0);
    random_phase(127, 31, 64'h1FF_FFFF_FFFF, 40, 0);
    random_phase(0, 0, 0, 12, 0);
    random_phase(3, 2, 256, 46, 1);
    random_phase(64, 16, 64'd1099511627776, 40, 0);

    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    $display("covered %0d request words and %0d result words", sent, results);
    $display("across seven register settings plus reset values, one long output stall");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ buffer_slot_lease_manager.f @@
rtl/bslm_pkg.sv
rtl/bslm_slot_table.sv
rtl/buffer_slot_lease_manager.sv
tb/sv/bslm_checker.sv
tb/sv/tb.sv
